/* src/promoting_hash_cache_top_defines.svh */
// Assertion macros shared by the promoting hash cache RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PROMOTING_HASH_CACHE_TOP_DEFINES_SVH
`define PROMOTING_HASH_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, checks off while in reset
`define PHC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checks off while in reset
`define PHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/phc_pkg.sv */
// Shared types and constants for the promoting hash cache.
// No dependencies; used by phc_mem and promoting_hash_cache_top.
`default_nettype none

package phc_pkg;

    // Default geometry
    localparam int DEF_ENTRIES      = 8;
    localparam int DEF_KEY_BITS     = 32;
    localparam int DEF_PAYLOAD_BITS = 16;

    // Victim pick field width (fixed by the command format)
    localparam int PICK_BITS = 2;

    // Command codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_INS
    } phc_state_t;

endpackage

`default_nettype wire

/* src/phc_mem.sv */
// Entry storage for the promoting hash cache: one write port, one read port.
// Read data is registered; depends on phc_pkg for default geometry only.
`default_nettype none

module phc_mem #(
    parameter int DEPTH = phc_pkg::DEF_ENTRIES,
    parameter int WIDTH = phc_pkg::DEF_KEY_BITS + phc_pkg::DEF_PAYLOAD_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/promoting_hash_cache_top.sv */
// Promoting hash cache: fully associative key/payload cache with
// promotion on hit (slot i moves to slot i/2) and replacement in the bottom half chosen by victim_pick.
// Depends on phc_pkg, phc_mem and promoting_hash_cache_top_defines.svh.
//
// Usage:
//   Command channel: a beat is taken at a clock edge with start high and busy
//   low. action selects lookup or insert; key, payload, payload_nonempty and
//   victim_pick go with it. busy stays high until the command is done.
//   Result channel: done pulses for one cycle with hit, payload_out, slot and
//   written valid in that cycle. The receiver cannot stall it; busy is already
//   low in the done cycle, so the next command may be issued then.
//   States visited per command, from the accepting edge to done:
//     lookup hit at slot 0      : SCAN
//     lookup hit at slot i > 0  : SCAN up to slot i, then swap via SWAP_A and SWAP_B
//     lookup miss               : SCAN over all ENTRIES slots
//     insert (stored or dropped): INS
//   The scan reads one entry per cycle through the single read port of the
//   entry memory; the swap uses its single write port twice.
//   Reset clears all valid bits and the sequencer; entry memory needs no clear.
`default_nettype none
`include "promoting_hash_cache_top_defines.svh"

module promoting_hash_cache_top #(
    parameter int ENTRIES      = phc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS     = phc_pkg::DEF_KEY_BITS,
    parameter int PAYLOAD_BITS = phc_pkg::DEF_PAYLOAD_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          action,
    input  wire logic [KEY_BITS-1:0]           key,
    input  wire logic [PAYLOAD_BITS-1:0]       payload,
    input  wire logic                          payload_nonempty,
    input  wire logic [phc_pkg::PICK_BITS-1:0] victim_pick,
    output logic                               done,
    output logic                               hit,
    output logic      [PAYLOAD_BITS-1:0]       payload_out,
    output logic      [$clog2(ENTRIES)-1:0]    slot,
    output logic                               written
);

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int HALF     = ENTRIES / 2;
    localparam int DW       = KEY_BITS + PAYLOAD_BITS;
    localparam int PICK_MAX = (1 << phc_pkg::PICK_BITS) - 1;

    // Reduce the victim pick into the bottom half and map to a slot
    function automatic logic [IDX_W-1:0] victim_slot(
        input logic [phc_pkg::PICK_BITS-1:0] pick
    );
        logic [phc_pkg::PICK_BITS-1:0] p;
        p = pick;
        for (int n = 0; n < PICK_MAX; n++)
        begin
            if (int'(p) >= HALF)
            begin
                p = p - phc_pkg::PICK_BITS'(HALF);
            end
        end
        return IDX_W'(ENTRIES - 1) - IDX_W'(p);
    endfunction

    phc_pkg::phc_state_t state_reg, state_next;

    logic [ENTRIES-1:0]            valid_reg, valid_next;
    logic [KEY_BITS-1:0]           key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]       payload_reg, payload_next;
    logic                          nonempty_reg, nonempty_next;
    logic [phc_pkg::PICK_BITS-1:0] pick_reg, pick_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]              hit_idx_reg, hit_idx_next;
    logic [PAYLOAD_BITS-1:0]       hit_pay_reg, hit_pay_next;

    logic                          done_reg, done_next;
    logic                          hit_reg, hit_next;
    logic [PAYLOAD_BITS-1:0]       pay_out_reg, pay_out_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic                          written_reg, written_next;

    // Memory port signals
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [DW-1:0]    mem_rdata;

    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    match;
    logic [IDX_W-1:0]        dest_idx;
    logic [IDX_W-1:0]        ins_idx;

    phc_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (DW),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Split read entry and compare against the searched key
    assign rd_key   = mem_rdata[DW-1:PAYLOAD_BITS];
    assign rd_pay   = mem_rdata[PAYLOAD_BITS-1:0];
    assign match    = valid_reg[cmp_idx_reg] && (rd_key == key_reg);
    assign dest_idx = hit_idx_reg >> 1;
    assign ins_idx  = victim_slot(pick_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phc_pkg::ST_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Datapath and result registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        payload_reg  <= payload_next;
        nonempty_reg <= nonempty_next;
        pick_reg     <= pick_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_pay_reg  <= hit_pay_next;
        hit_reg      <= hit_next;
        pay_out_reg  <= pay_out_next;
        slot_reg     <= slot_next;
        written_reg  <= written_next;
    end

    // Sequencer: next state, memory control, results
    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        key_next      = key_reg;
        payload_next  = payload_reg;
        nonempty_next = nonempty_reg;
        pick_next     = pick_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_idx_next  = hit_idx_reg;
        hit_pay_next  = hit_pay_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;
        pay_out_next  = pay_out_reg;
        slot_next     = slot_reg;
        written_next  = written_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        case (state_reg)
            phc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    key_next      = key;
                    payload_next  = payload;
                    nonempty_next = payload_nonempty;
                    pick_next     = victim_pick;
                    if (action == phc_pkg::ACT_LOOKUP)
                    begin
                        // fetch slot 0
                        mem_re       = 1'b1;
                        mem_raddr    = '0;
                        cmp_idx_next = '0;
                        state_next   = phc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = phc_pkg::ST_INS;
                    end
                end
            end

            phc_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    hit_idx_next = cmp_idx_reg;
                    hit_pay_next = rd_pay;
                    if (cmp_idx_reg == '0)
                    begin
                        // front entry: nothing moves
                        done_next    = 1'b1;
                        hit_next     = 1'b1;
                        pay_out_next = rd_pay;
                        slot_next    = '0;
                        written_next = 1'b0;
                        state_next   = phc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // fetch the entry being displaced
                        mem_re     = 1'b1;
                        mem_raddr  = cmp_idx_reg >> 1;
                        state_next = phc_pkg::ST_SWAP_A;
                    end
                end
                else if (cmp_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    // miss
                    done_next    = 1'b1;
                    hit_next     = 1'b0;
                    pay_out_next = '0;
                    slot_next    = '0;
                    written_next = 1'b0;
                    state_next   = phc_pkg::ST_IDLE;
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = cmp_idx_reg + 1'b1;
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                end
            end

            phc_pkg::ST_SWAP_A:
            begin
                // displaced entry moves down to the hit slot
                mem_we     = 1'b1;
                mem_waddr  = hit_idx_reg;
                mem_wdata  = mem_rdata;
                state_next = phc_pkg::ST_SWAP_B;
            end

            phc_pkg::ST_SWAP_B:
            begin
                // hit entry moves up; valid bits trade places
                mem_we               = 1'b1;
                mem_waddr            = dest_idx;
                mem_wdata            = {key_reg, hit_pay_reg};
                valid_next[dest_idx] = 1'b1;
                valid_next[hit_idx_reg] = valid_reg[dest_idx];
                done_next            = 1'b1;
                hit_next             = 1'b1;
                pay_out_next         = hit_pay_reg;
                slot_next            = dest_idx;
                written_next         = 1'b0;
                state_next           = phc_pkg::ST_IDLE;
            end

            phc_pkg::ST_INS:
            begin
                done_next    = 1'b1;
                hit_next     = 1'b0;
                pay_out_next = '0;
                if (nonempty_reg)
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = ins_idx;
                    mem_wdata           = {key_reg, payload_reg};
                    valid_next[ins_idx] = 1'b1;
                    slot_next           = ins_idx;
                    written_next        = 1'b1;
                end
                else
                begin
                    slot_next    = '0;
                    written_next = 1'b0;
                end
                state_next = phc_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = phc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != phc_pkg::ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign payload_out = pay_out_reg;
    assign slot        = slot_reg;
    assign written     = written_reg;

    // Checks
    `PHC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `PHC_ASSERT_IMPL(a_hit_xor_wr, clk, rst_n, done, !(hit && written), "hit and written together")
    `PHC_ASSERT_IMPL(a_scan_no_wr, clk, rst_n, state_reg == phc_pkg::ST_SCAN, !mem_we, "memory written during scan")
    `PHC_ASSERT_IMPL(a_ins_bottom, clk, rst_n, done && written, slot >= IDX_W'(HALF), "insert outside bottom half")

endmodule

`default_nettype wire
